>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the RTL, removable with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> rtl/core/hitl_pkg.sv
// ----------------------------------------------------------------------------
// hitl_pkg
// Types and constants of the hash id interning table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hitl_pkg;

  localparam int CAPACITY = 1024;
  localparam int CAP_W    = $clog2(CAPACITY);
  localparam int KEY_W    = 32;
  localparam int ID_W     = 10;
  localparam int CNT_W    = 11;
  localparam int STATUS_W = 2;

  localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E37_79B9;
  localparam logic [KEY_W-1:0] BAD_KEY   = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] FILL_LIMIT_RST = 11'd768;

  typedef enum logic {
    OP_GET_INSERT = 1'b0,
    OP_CLEAR      = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_BAD_KEY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_CLEAR,
    ST_REPLY
  } state_e;

  typedef enum logic [2:0] {
    RES_CLEAR,
    RES_BAD_KEY,
    RES_FULL,
    RES_FOUND,
    RES_INSERT
  } res_e;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } slot_t;

  typedef struct packed {
    logic accept;
    logic hash_start;
    logic advance;
    logic sweep_step;
    logic clear_count;
    logic write_entry;
    logic load_out;
    res_e res_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_bad_key;
    logic op_clear;
    logic slot_valid;
    logic slot_match;
    logic count_full;
    logic probe_last;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/core/hitl_dp.sv
// ----------------------------------------------------------------------------
// hitl_dp
// Datapath: hash, slot memory, probe index, entry count and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hitl_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hitl_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic                              opcode_i,
  input  logic signed [hitl_pkg::KEY_W-1:0] key_i,
  output logic [hitl_pkg::ID_W-1:0]         id_o,
  output logic                              inserted_o,
  output logic [hitl_pkg::STATUS_W-1:0]     status_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  hitl_pkg::ctrl_cmd_t               cmd_i,
  output hitl_pkg::dp_sts_t                 sts_o
);

  logic [hitl_pkg::CNT_W-1:0]    fill_limit_q;
  logic                          op_clear_q;
  logic [hitl_pkg::KEY_W-1:0]    key_q;
  logic [hitl_pkg::CAP_W-1:0]    idx_q, idx_d;
  logic [hitl_pkg::CAP_W-1:0]    probe_cnt_q, probe_cnt_d;
  logic [hitl_pkg::CAP_W-1:0]    sweep_addr_q;
  logic [hitl_pkg::CNT_W-1:0]    count_q, count_d;
  logic [hitl_pkg::KEY_W-1:0]    hash_prod;
  hitl_pkg::slot_t               slot_mem_q [hitl_pkg::CAPACITY];
  hitl_pkg::slot_t               rdata_q;
  hitl_pkg::slot_t               mem_wdata;
  logic [hitl_pkg::CAP_W-1:0]    mem_waddr;
  logic                          mem_we;
  logic                          out_valid_q;
  logic [hitl_pkg::ID_W-1:0]     out_id_q, out_id_d;
  logic                          out_ins_q, out_ins_d;
  logic [hitl_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic                          out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_limit_q <= hitl_pkg::FILL_LIMIT_RST;
    end else if (cfg_we_i) begin
      fill_limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_clear_q <= opcode_i;
      key_q      <= key_i;
    end
  end

  assign hash_prod = key_q * hitl_pkg::HASH_MULT;

  always_comb begin
    idx_d       = idx_q;
    probe_cnt_d = probe_cnt_q;
    if (cmd_i.hash_start) begin
      idx_d       = hash_prod[hitl_pkg::CAP_W-1:0];
      probe_cnt_d = '0;
    end else if (cmd_i.advance) begin
      idx_d       = idx_q + 1'b1;
      probe_cnt_d = probe_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    probe_cnt_q <= probe_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_addr_q <= '0;
    end else if (cmd_i.sweep_step) begin
      sweep_addr_q <= sweep_addr_q + 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear_count) begin
      count_d = '0;
    end else if (cmd_i.write_entry) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    mem_we    = cmd_i.sweep_step || cmd_i.write_entry;
    mem_waddr = idx_q;
    mem_wdata = '{valid: 1'b1, id: count_q[hitl_pkg::ID_W-1:0], key: key_q};
    if (cmd_i.sweep_step) begin
      mem_waddr = sweep_addr_q;
      mem_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= slot_mem_q[idx_d];
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_id_d     = '0;
    out_ins_d    = 1'b0;
    out_status_d = hitl_pkg::STATUS_OK;
    case (cmd_i.res_kind)
      hitl_pkg::RES_BAD_KEY: out_status_d = hitl_pkg::STATUS_BAD_KEY;
      hitl_pkg::RES_FULL:    out_status_d = hitl_pkg::STATUS_FULL;
      hitl_pkg::RES_FOUND:   out_id_d     = rdata_q.id;
      hitl_pkg::RES_INSERT: begin
        out_id_d  = count_q[hitl_pkg::ID_W-1:0];
        out_ins_d = 1'b1;
      end
      default: out_status_d = hitl_pkg::STATUS_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_id_q     <= out_id_d;
      out_ins_q    <= out_ins_d;
      out_status_q <= out_status_d;
    end
  end

  assign id_o        = out_id_q;
  assign inserted_o  = out_ins_q;
  assign status_o    = out_status_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o            = '0;
    sts_o.in_clear   = (opcode_i == hitl_pkg::OP_CLEAR);
    sts_o.in_bad_key = (key_i == hitl_pkg::BAD_KEY);
    sts_o.op_clear   = op_clear_q;
    sts_o.slot_valid = rdata_q.valid;
    sts_o.slot_match = (rdata_q.key == key_q);
    sts_o.count_full = (count_q >= fill_limit_q) || (32'(count_q) >= hitl_pkg::CAPACITY);
    sts_o.probe_last = (probe_cnt_q == hitl_pkg::CAP_W'(hitl_pkg::CAPACITY - 1));
    sts_o.sweep_last = (sweep_addr_q == hitl_pkg::CAP_W'(hitl_pkg::CAPACITY - 1));
    sts_o.out_free   = out_free;
  end

  `ASSERT_CLK(a_insert_into_empty, clk_i, rst_ni, cmd_i.write_entry |-> !rdata_q.valid)
  `ASSERT_CLK(a_count_bounded, clk_i, rst_ni, 32'(count_q) <= hitl_pkg::CAPACITY)
  `ASSERT_CLK(a_load_shows, clk_i, rst_ni, cmd_i.load_out |=> out_valid_q)
  `ASSERT_NEVER(a_load_overrun, clk_i, rst_ni, cmd_i.load_out && !out_free)

endmodule

>>> rtl/core/hitl_ctrl.sv
// ----------------------------------------------------------------------------
// hitl_ctrl
// Controller: init sweep, accept, hash, probe walk, clear sweep and reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hitl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hitl_pkg::dp_sts_t   sts_i,
  output hitl_pkg::ctrl_cmd_t cmd_o
);

  hitl_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hitl_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hitl_pkg::ST_INIT: begin
        if (sts_i.sweep_last) state_d = hitl_pkg::ST_IDLE;
      end
      hitl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.in_clear) state_d = hitl_pkg::ST_CLEAR;
          else if (sts_i.in_bad_key) state_d = hitl_pkg::ST_REPLY;
          else state_d = hitl_pkg::ST_HASH;
        end
      end
      hitl_pkg::ST_HASH: state_d = hitl_pkg::ST_PROBE;
      hitl_pkg::ST_PROBE: begin
        if ((!sts_i.slot_valid || sts_i.slot_match || sts_i.probe_last) && sts_i.out_free) begin
          state_d = hitl_pkg::ST_IDLE;
        end
      end
      hitl_pkg::ST_CLEAR: begin
        if (sts_i.sweep_last) state_d = hitl_pkg::ST_REPLY;
      end
      hitl_pkg::ST_REPLY: begin
        if (sts_i.out_free) state_d = hitl_pkg::ST_IDLE;
      end
      default: state_d = hitl_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.res_kind = hitl_pkg::RES_CLEAR;
    in_stall_o     = 1'b1;
    unique case (state_q)
      hitl_pkg::ST_INIT: cmd_o.sweep_step = 1'b1;
      hitl_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      hitl_pkg::ST_HASH: cmd_o.hash_start = 1'b1;
      hitl_pkg::ST_PROBE: begin
        if (!sts_i.slot_valid) begin
          cmd_o.load_out = sts_i.out_free;
          if (sts_i.count_full) begin
            cmd_o.res_kind = hitl_pkg::RES_FULL;
          end else begin
            cmd_o.res_kind    = hitl_pkg::RES_INSERT;
            cmd_o.write_entry = sts_i.out_free;
          end
        end else if (sts_i.slot_match) begin
          cmd_o.load_out = sts_i.out_free;
          cmd_o.res_kind = hitl_pkg::RES_FOUND;
        end else if (sts_i.probe_last) begin
          cmd_o.load_out = sts_i.out_free;
          cmd_o.res_kind = hitl_pkg::RES_FULL;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      hitl_pkg::ST_CLEAR: begin
        cmd_o.sweep_step  = 1'b1;
        cmd_o.clear_count = sts_i.sweep_last;
      end
      hitl_pkg::ST_REPLY: begin
        cmd_o.load_out = sts_i.out_free;
        cmd_o.res_kind = sts_i.op_clear ? hitl_pkg::RES_CLEAR : hitl_pkg::RES_BAD_KEY;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> rtl/core/hash_id_interning_table_core.sv
// ----------------------------------------------------------------------------
// hash_id_interning_table_core
// Interns 32-bit keys into dense ids with a linear-probing hash table.
//
//   port group   direction  handshake               payload
//   input        in         in_valid_i/in_stall_o   opcode_i, key_i
//   result       out        out_valid_o/out_stall_i id_o, inserted_o, status_o
//   config       in         cfg_we_i                cfg_wdata_i (fill limit)
//
// A lookup or insert runs from transfer through the hash state and P probe
// steps to the result register, P being the number of probes; each probe
// is one read of the slot memory. A bad key goes straight to the reply
// state. A clear sweeps all 1024 slots, one per cycle. After reset the same
// sweep of all 1024 slots runs before the first transfer. A stalled result
// holds in the output register; the next item is taken while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hash_id_interning_table_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hitl_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic signed [hitl_pkg::KEY_W-1:0] key_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hitl_pkg::ID_W-1:0]         id_o,
  output logic                              inserted_o,
  output logic [hitl_pkg::STATUS_W-1:0]     status_o
);

  hitl_pkg::ctrl_cmd_t cmd;
  hitl_pkg::dp_sts_t   sts;

  hitl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hitl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .id_o        (id_o),
    .inserted_o  (inserted_o),
    .status_o    (status_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> verif/intern_check_pkg.sv
// ----------------------------------------------------------------------------
// intern_check_pkg
// Scoreboard of the hash id interning table: keeps its own copy of the slot
// table, count and fill limit, works out the result of every accepted item
// and compares the results of the core with them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package intern_check_pkg;

  import hitl_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            inserted;
    status_e         status;
  } intern_result_t;

  class intern_scoreboard;
    logic [KEY_W-1:0] slot_key   [CAPACITY];
    logic [ID_W-1:0]  slot_id    [CAPACITY];
    bit               slot_valid [CAPACITY];
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] fill_limit;
    intern_result_t   awaited_results [$];
    int               errors;

    function new();
      slot_valid  = '{default: 1'b0};
      entry_count = '0;
      fill_limit  = FILL_LIMIT_RST;
      errors      = 0;
    endfunction

    function void set_fill_limit(logic [CNT_W-1:0] value);
      fill_limit = value;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void intern_lookup(opcode_e op, logic [KEY_W-1:0] key);
      intern_result_t   res;
      logic [KEY_W-1:0] product;
      logic [CAP_W-1:0] slot;
      int unsigned      limit;
      bit               settled;
      res.id       = '0;
      res.inserted = 1'b0;
      res.status   = STATUS_OK;
      settled      = 1'b0;
      if (op == OP_CLEAR) begin
        slot_valid  = '{default: 1'b0};
        entry_count = '0;
      end else if (key == BAD_KEY) begin
        res.status = STATUS_BAD_KEY;
      end else begin
        limit      = (fill_limit < CAPACITY) ? fill_limit : CAPACITY;
        product    = key * HASH_MULT;
        slot       = product[CAP_W-1:0];
        res.status = STATUS_FULL;
        for (int n = 0; n < CAPACITY && !settled; n++) begin
          if (!slot_valid[slot]) begin
            settled = 1'b1;
            if (entry_count < limit) begin
              slot_valid[slot] = 1'b1;
              slot_key[slot]   = key;
              slot_id[slot]    = entry_count[ID_W-1:0];
              res.id           = entry_count[ID_W-1:0];
              res.inserted     = 1'b1;
              res.status       = STATUS_OK;
              entry_count      = entry_count + 1'b1;
            end
          end else if (slot_key[slot] == key) begin
            settled    = 1'b1;
            res.id     = slot_id[slot];
            res.status = STATUS_OK;
          end else begin
            slot = slot + 1'b1;
          end
        end
      end
      awaited_results.push_back(res);
    endfunction

    function void check_result(logic [ID_W-1:0] id, logic inserted,
                               logic [STATUS_W-1:0] status);
      intern_result_t want;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: id %0d inserted %0d status %0d", id, inserted, status);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (id !== want.id) begin
        $error("id mismatch: expected %0d, actual %0d", want.id, id);
        errors++;
      end
      if (inserted !== want.inserted) begin
        $error("inserted mismatch: expected %0d, actual %0d", want.inserted, inserted);
        errors++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, status);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of hash_id_interning_table_core. A directed run covers extreme
// keys, the bad key, collisions, probing across the table end, clears and
// refused inserts; random phases then mix repeated, colliding and fresh keys
// under several fill limits and idle patterns, and one phase fills every
// slot so that probes run through the whole table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  import hitl_pkg::*;
  import intern_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          MIX_ITEMS     = 45;
  localparam int          POOL_DEPTH    = 64;
  localparam int          PHASES        = 8;
  localparam int          FILL_PHASE    = 6;
  localparam int          RANDOM_LIMIT_PHASE = 5;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                opcode_i    = OP_GET_INSERT;
  logic [KEY_W-1:0]    key_i       = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [ID_W-1:0]     id_o;
  logic                inserted_o;
  logic [STATUS_W-1:0] status_o;

  int               gap_pct     = 0;
  int               stall_pct   = 0;
  int unsigned      cycle_count = 0;
  logic [KEY_W-1:0] wrap_key    = '0;
  logic [KEY_W-1:0] key_pool [$];
  int               phase_limit [PHASES] = '{768, 1, 16, 0, 2047, 0, 1024, 40};
  intern_scoreboard sb;

  hash_id_interning_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .id_o        (id_o),
    .inserted_o  (inserted_o),
    .status_o    (status_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(id_o, inserted_o, status_o);
    end
  end

  task automatic drive_item(opcode_e op, logic [KEY_W-1:0] key);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    key_i      <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.intern_lookup(op, key);
    if (op == OP_GET_INSERT && key != BAD_KEY) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_fill_limit(logic [CNT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_fill_limit(value);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned      roll;
    logic [KEY_W-1:0] k;
    roll = $urandom_range(0, 99);
    k    = $urandom();
    if (roll < 4) begin
      k = BAD_KEY;
    end else if (roll < 44 && key_pool.size() > 0) begin
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if (roll < 66) begin
      if ($urandom_range(0, 7) == 0) k[CAP_W-1:0] = wrap_key[CAP_W-1:0];
      else k[CAP_W-1:0] = CAP_W'($urandom_range(0, 6));
    end
    return k;
  endfunction

  initial begin : stimulus
    logic [KEY_W-1:0] hash_val;
    logic [KEY_W-1:0] k;
    logic [CNT_W-1:0] limit;
    logic [KEY_W-1:0] fill_keys [$];
    bit               used_keys [logic [KEY_W-1:0]];
    int               n_items;
    sb = new();
    for (int h = 0; h < CAPACITY; h++) begin
      hash_val = h * HASH_MULT;
      if (hash_val[CAP_W-1:0] == {CAP_W{1'b1}}) wrap_key = h;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    drive_item(OP_GET_INSERT, 32'h0000_0000);
    drive_item(OP_GET_INSERT, 32'h8000_0000);
    drive_item(OP_GET_INSERT, 32'h7FFF_FFFF);
    drive_item(OP_GET_INSERT, BAD_KEY);
    drive_item(OP_GET_INSERT, 32'h0000_0000);
    drive_item(OP_GET_INSERT, 32'd5);
    drive_item(OP_GET_INSERT, 32'd1029);
    drive_item(OP_GET_INSERT, 32'd2053);
    drive_item(OP_GET_INSERT, 32'd2053);
    drive_item(OP_GET_INSERT, 32'hFFFF_FFFE);
    drive_item(OP_CLEAR, BAD_KEY);
    drive_item(OP_GET_INSERT, 32'h0000_0000);
    drive_item(OP_GET_INSERT, 32'd2053);
    drive_item(OP_GET_INSERT, 32'd5);
    drive_item(OP_GET_INSERT, wrap_key);
    drive_item(OP_GET_INSERT, wrap_key + 32'd1024);
    drive_item(OP_GET_INSERT, wrap_key + 32'd1024);
    drain_results();
    write_fill_limit(CNT_W'(2));
    drive_item(OP_GET_INSERT, 32'd7);
    drive_item(OP_GET_INSERT, 32'h0000_0000);
    drive_item(OP_CLEAR, $urandom());
    drive_item(OP_GET_INSERT, 32'd7);
    drive_item(OP_GET_INSERT, 32'd9);
    drive_item(OP_GET_INSERT, 32'd11);
    drain_results();
    write_fill_limit(CNT_W'(0));
    drive_item(OP_GET_INSERT, 32'd7);
    drive_item(OP_GET_INSERT, 32'd13);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 48; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 48; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      if (p == RANDOM_LIMIT_PHASE) limit = CNT_W'($urandom_range(1, CAPACITY));
      else limit = CNT_W'(phase_limit[p]);
      write_fill_limit(limit);
      drive_item(OP_CLEAR, $urandom());
      if (p == FILL_PHASE) begin
        fill_keys.delete();
        used_keys.delete();
        while (fill_keys.size() < CAPACITY) begin
          k = $urandom();
          if (k != BAD_KEY && !used_keys.exists(k)) begin
            used_keys[k] = 1'b1;
            fill_keys.push_back(k);
            drive_item(OP_GET_INSERT, k);
          end
        end
        for (int j = 0; j < 12; j++) begin
          if (j % 2 == 1) begin
            drive_item(OP_GET_INSERT, fill_keys[$urandom_range(0, CAPACITY - 1)]);
          end else begin
            do k = $urandom(); while (used_keys.exists(k) || k == BAD_KEY);
            drive_item(OP_GET_INSERT, k);
          end
        end
      end else begin
        n_items = (p == 3) ? 30 : MIX_ITEMS;
        for (int j = 0; j < n_items; j++) begin
          if ($urandom_range(0, 99) < 3) drive_item(OP_CLEAR, $urandom());
          else drive_item(OP_GET_INSERT, pick_key());
        end
      end
    end

    drain_results();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> hash_id_interning_table_core.f
+incdir+rtl/core
rtl/core/hitl_pkg.sv
rtl/core/hitl_dp.sv
rtl/core/hitl_ctrl.sv
rtl/core/hash_id_interning_table_core.sv
verif/intern_check_pkg.sv
verif/tb_top.sv
